// ===== hw/rtl/key_debounce_and_knob_decoder_unit_assert.svh =====
// assertion macros for the key debounce and knob decoder unit
// expects clk and arst_n in the scope of use
`ifndef KEY_DEBOUNCE_AND_KNOB_DECODER_UNIT_ASSERT_SVH
`define KEY_DEBOUNCE_AND_KNOB_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define KDK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KDK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kdk_pkg.sv =====
// shared types and constants for the key debounce and knob decoder unit
// no dependencies
`timescale 1ns / 1ps

package kdk_pkg;

	localparam int KEY_W      = 6;
	localparam int DEB_W      = 8;
	localparam int TICK_W     = 16;
	localparam int HOLDOFF_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SCANS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KNOB_HOLDOFF   = 2'd3;

	localparam logic [DEB_W-1:0]     DEBOUNCE_RST = 8'd1;
	localparam logic [TICK_W-1:0]    LONG_RST     = 16'd3000;
	localparam logic [TICK_W-1:0]    REPEAT_RST   = 16'd500;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST  = 8'd60;

	localparam logic [KEY_W-1:0] KEY_SIX = 6'h20;

	// knob pin codes, {~pin_a, ~pin_b}
	localparam logic [1:0] KNOB_00 = 2'd0;
	localparam logic [1:0] KNOB_01 = 2'd1;
	localparam logic [1:0] KNOB_10 = 2'd2;
	localparam logic [1:0] KNOB_11 = 2'd3;

	typedef struct packed {
		logic             turn_down;
		logic             turn_up;
		logic             long_press;
		logic [KEY_W-1:0] released_mask;
		logic [KEY_W-1:0] pressed_mask;
		logic [KEY_W-1:0] stable_keys;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/key_debounce_and_knob_decoder_unit.sv =====
// key debounce and knob decoder unit, top level
// depends on kdk_pkg and key_debounce_and_knob_decoder_unit_assert.svh
//
// channel   dir  width  accepted when
// s_*       in   16     s_tvalid & s_tready
// m_*       out  24     m_tvalid & m_tready
// cfg_*     in   2/16   cfg_we
//
// one scan per cycle while s_tready is high; each scan yields one result, registered
// in the result register; a skid register takes one more scan while a result waits,
// so s_tready drops only after two stalled results
// arst_n clears all scan state and loads the register defaults
`timescale 1ns / 1ps

module key_debounce_and_knob_decoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [kdk_pkg::IN_TDATA_W-1:0]     s_tdata,  // raw_keys, pin_a, pin_b, ms_tick
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [kdk_pkg::OUT_TDATA_W-1:0]    m_tdata,  // stable_keys, pressed_mask,
	                                                     // released_mask, long_press,
	                                                     // turn_up, turn_down
	input  logic                               cfg_we,
	input  logic [kdk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kdk_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import kdk_pkg::*;

	`include "key_debounce_and_knob_decoder_unit_assert.svh"

	logic [DEB_W-1:0]     debounce_scans_q;
	logic [TICK_W-1:0]    long_press_ticks_q;
	logic [TICK_W-1:0]    repeat_ticks_q;
	logic [HOLDOFF_W-1:0] holdoff_ticks_q;

	logic [KEY_W-1:0]     cand_q, accepted_q, prev_q;
	logic [DEB_W-1:0]     deb_cnt_q;
	logic [TICK_W-1:0]    hold_q;
	logic [1:0]           rest_q, half_q;
	logic                 parity_q;
	logic [HOLDOFF_W-1:0] holdoff_q;

	logic [KEY_W-1:0]     cand_d, accepted_d;
	logic [DEB_W-1:0]     deb_cnt_d;
	logic [TICK_W-1:0]    hold_d, hold_dec;
	logic [1:0]           rest_d, half_d, half_a, code;
	logic                 parity_d;
	logic [HOLDOFF_W-1:0] holdoff_d;
	logic                 tick, up_hit, down_hit;
	logic [KEY_W-1:0]     raw;
	result_t              res;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    acc, take;

	assign raw  = s_tdata[KEY_W-1:0];
	assign tick = s_tdata[KEY_W+2];
	assign code = {~s_tdata[KEY_W], ~s_tdata[KEY_W+1]};

	assign s_tready = !skid_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign take     = out_valid_q && m_tready;
	assign m_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_q};

	always_comb begin
		res        = '0;
		deb_cnt_d  = (deb_cnt_q != '0) ? deb_cnt_q - 1'b1 : deb_cnt_q;
		cand_d     = cand_q;
		accepted_d = accepted_q;
		if (raw == cand_q) begin
			if (deb_cnt_d == '0) begin
				accepted_d = raw;
			end
		end else begin
			cand_d    = raw;
			deb_cnt_d = debounce_scans_q;
		end

		// key edges and key six hold counter
		res.stable_keys   = accepted_d;
		res.pressed_mask  = accepted_d & ~prev_q;
		res.released_mask = prev_q & ~accepted_d;
		hold_d = hold_q;
		if (res.pressed_mask[KEY_W-1]) begin
			hold_d = long_press_ticks_q;
		end else if (res.released_mask[KEY_W-1]) begin
			hold_d = '0;
		end
		hold_dec = hold_d - 1'b1;
		if (tick && accepted_d == KEY_SIX) begin
			if (hold_dec == '0) begin
				hold_d         = repeat_ticks_q;
				res.long_press = 1'b1;
			end else begin
				hold_d = hold_dec;
			end
		end

		holdoff_d = (tick && holdoff_q != '0) ? holdoff_q - 1'b1 : holdoff_q;

		// knob decode
		rest_d   = rest_q;
		half_d   = half_q;
		parity_d = parity_q;
		half_a   = half_q;
		up_hit   = 1'b0;
		down_hit = 1'b0;
		if (code != rest_q && holdoff_d == '0) begin
			if ((code == KNOB_01 && rest_q == KNOB_00) ||
				(code == KNOB_10 && rest_q == KNOB_11)) begin
				half_a = code;
			end
			up_hit = (code == KNOB_11 && rest_q == KNOB_00 && half_a == KNOB_01) ||
				(code == KNOB_00 && rest_q == KNOB_11 && half_a == KNOB_10);
			half_d = half_a;
			if (!up_hit) begin
				if ((code == KNOB_10 && rest_q == KNOB_00) ||
					(code == KNOB_01 && rest_q == KNOB_11)) begin
					half_d = code;
				end
				down_hit = (code == KNOB_11 && rest_q == KNOB_00 && half_d == KNOB_10) ||
					(code == KNOB_00 && rest_q == KNOB_11 && half_d == KNOB_01);
			end
			if (up_hit || down_hit) begin
				rest_d   = code;
				half_d   = KNOB_00;
				parity_d = !parity_q;
				if (parity_q) begin
					holdoff_d     = holdoff_ticks_q;
					res.turn_up   = up_hit;
					res.turn_down = down_hit;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_scans_q   <= DEBOUNCE_RST;
			long_press_ticks_q <= LONG_RST;
			repeat_ticks_q     <= REPEAT_RST;
			holdoff_ticks_q    <= HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE_SCANS: debounce_scans_q   <= cfg_data[DEB_W-1:0];
				REG_LONG_PRESS:     long_press_ticks_q <= cfg_data[TICK_W-1:0];
				REG_REPEAT:         repeat_ticks_q     <= cfg_data[TICK_W-1:0];
				REG_KNOB_HOLDOFF:   holdoff_ticks_q    <= cfg_data[HOLDOFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= '0;
			deb_cnt_q  <= '0;
			accepted_q <= '0;
			prev_q     <= '0;
			hold_q     <= '0;
			rest_q     <= '0;
			half_q     <= '0;
			parity_q   <= 1'b0;
			holdoff_q  <= '0;
		end else if (acc) begin
			cand_q     <= cand_d;
			deb_cnt_q  <= deb_cnt_d;
			accepted_q <= accepted_d;
			prev_q     <= accepted_d;
			hold_q     <= hold_d;
			rest_q     <= rest_d;
			half_q     <= half_d;
			parity_q   <= parity_d;
			holdoff_q  <= holdoff_d;
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res;
			end
		end else if (acc) begin
			skid_q <= res;
		end
	end

	`KDK_ASSERT_NOW(a_skid_implies_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`KDK_ASSERT_NOW(a_turn_exclusive, m_tvalid, !(out_q.turn_up && out_q.turn_down), "both turn directions")
	`KDK_ASSERT_NOW(a_edges_disjoint, m_tvalid, (out_q.pressed_mask & out_q.released_mask) == '0, "key pressed and released together")
	`KDK_ASSERT_NEXT(a_holdoff_load, acc && (res.turn_up || res.turn_down), holdoff_q == $past(holdoff_ticks_q), "hold-off not loaded on turn")

endmodule

// ===== verif/kdk_scan_checker.sv =====
// scan checker for the key debounce and knob decoder unit: predicts each result and compares
// watches the scan, result and register write channels; depends on kdk_pkg
`timescale 1ns / 1ps

module kdk_scan_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [kdk_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [kdk_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [kdk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdk_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              outstanding
);
	import kdk_pkg::*;

	logic [DEB_W-1:0]     debounce_setting;
	logic [TICK_W-1:0]    long_setting;
	logic [TICK_W-1:0]    repeat_setting;
	logic [HOLDOFF_W-1:0] holdoff_setting;

	logic [KEY_W-1:0]     cand_keys;
	logic [DEB_W-1:0]     settle_left;
	logic [KEY_W-1:0]     stable_now;
	logic [KEY_W-1:0]     stable_prev;
	logic [TICK_W-1:0]    hold_left;
	logic [1:0]           rest_code;
	logic [1:0]           half_code;
	logic                 step_odd;
	logic [HOLDOFF_W-1:0] holdoff_left;

	result_t predicted_results[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// a confirmed step; every second one is a turn and starts the hold-off
	function automatic logic confirm_step(input logic [1:0] code);
		rest_code = code;
		half_code = KNOB_00;
		if (step_odd) begin
			step_odd = 1'b0;
			holdoff_left = holdoff_setting;
			return 1'b1;
		end
		step_odd = 1'b1;
		return 1'b0;
	endfunction

	function automatic result_t decode_scan(input logic [KEY_W-1:0] raw, input logic pin_a,
			input logic pin_b, input logic tick);
		result_t r;
		logic [1:0] code;
		logic [1:0] rest;
		r = '0;
		if (settle_left != 0) settle_left = settle_left - 1'b1;
		if (raw == cand_keys) begin
			if (settle_left == 0) stable_now = raw;
		end else begin
			cand_keys = raw;
			settle_left = debounce_setting;
		end

		if (stable_now != stable_prev) begin
			r.pressed_mask = stable_now & ~stable_prev;
			r.released_mask = stable_prev & ~stable_now;
			if (|(r.pressed_mask & KEY_SIX)) begin
				hold_left = long_setting;
			end else if (|(r.released_mask & KEY_SIX)) begin
				hold_left = '0;
			end
			stable_prev = stable_now;
		end

		if (tick && stable_now == KEY_SIX) begin
			hold_left = hold_left - 1'b1;
			if (hold_left == 0) begin
				hold_left = repeat_setting;
				r.long_press = 1'b1;
			end
		end

		if (tick && holdoff_left != 0) holdoff_left = holdoff_left - 1'b1;

		code = {~pin_a, ~pin_b};
		if (code != rest_code && holdoff_left == 0) begin
			rest = rest_code;
			if ((code == KNOB_01 && rest == KNOB_00) || (code == KNOB_10 && rest == KNOB_11))
				half_code = code;
			if ((code == KNOB_11 && rest == KNOB_00 && half_code == KNOB_01) ||
					(code == KNOB_00 && rest == KNOB_11 && half_code == KNOB_10))
				r.turn_up = confirm_step(code);
			rest = rest_code;
			if ((code == KNOB_10 && rest == KNOB_00) || (code == KNOB_01 && rest == KNOB_11))
				half_code = code;
			if ((code == KNOB_11 && rest == KNOB_00 && half_code == KNOB_10) ||
					(code == KNOB_00 && rest == KNOB_11 && half_code == KNOB_01))
				r.turn_down = confirm_step(code);
		end

		r.stable_keys = stable_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t got;
		result_t want;
		if (!arst_n) begin
			debounce_setting = DEBOUNCE_RST;
			long_setting = LONG_RST;
			repeat_setting = REPEAT_RST;
			holdoff_setting = HOLDOFF_RST;
			cand_keys = '0;
			settle_left = '0;
			stable_now = '0;
			stable_prev = '0;
			hold_left = '0;
			rest_code = KNOB_00;
			half_code = KNOB_00;
			step_odd = 1'b0;
			holdoff_left = '0;
			predicted_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_W-1:0]);
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no scan pending", int'(got), -1);
				end else begin
					want = predicted_results.pop_front();
					if (got.stable_keys !== want.stable_keys)
						report_mismatch("stable_keys", int'(got.stable_keys),
							int'(want.stable_keys));
					if (got.pressed_mask !== want.pressed_mask)
						report_mismatch("pressed_mask", int'(got.pressed_mask),
							int'(want.pressed_mask));
					if (got.released_mask !== want.released_mask)
						report_mismatch("released_mask", int'(got.released_mask),
							int'(want.released_mask));
					if (got.long_press !== want.long_press)
						report_mismatch("long_press", int'(got.long_press),
							int'(want.long_press));
					if (got.turn_up !== want.turn_up)
						report_mismatch("turn_up", int'(got.turn_up), int'(want.turn_up));
					if (got.turn_down !== want.turn_down)
						report_mismatch("turn_down", int'(got.turn_down),
							int'(want.turn_down));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE_SCANS: debounce_setting = cfg_data[DEB_W-1:0];
					REG_LONG_PRESS:     long_setting = cfg_data[TICK_W-1:0];
					REG_REPEAT:         repeat_setting = cfg_data[TICK_W-1:0];
					REG_KNOB_HOLDOFF:   holdoff_setting = cfg_data[HOLDOFF_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(decode_scan(s_tdata[KEY_W-1:0], s_tdata[KEY_W],
					s_tdata[KEY_W+1], s_tdata[KEY_W+2]));
			end
		end
		outstanding = predicted_results.size();
	end

endmodule

// ===== verif/tb_key_debounce_and_knob_decoder_unit.sv =====
// testbench top for the key debounce and knob decoder unit: scan stimulus, register phases
// depends on kdk_pkg, key_debounce_and_knob_decoder_unit and kdk_scan_checker
`timescale 1ns / 1ps

module tb_key_debounce_and_knob_decoder_unit;
	import kdk_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_DEB [PHASES]   = '{1, 0, 3, 2, 5, 255, 1, 4};
	localparam int PHASE_LONG [PHASES]  = '{1, 0, 6, 4, 20, 65535, 2, 9};
	localparam int PHASE_REP [PHASES]   = '{1, 0, 2, 3, 7, 65535, 1, 4};
	localparam int PHASE_HOLD [PHASES]  = '{0, 0, 3, 1, 10, 255, 0, 6};
	localparam int PHASE_SCANS [PHASES] = '{80, 60, 80, 80, 60, 280, 60, 80};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_DEBOUNCE_SCANS;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatch_count;
	int outstanding;
	int cycles = 0;
	int scans_sent = 0;
	int send_gap_pct = 9;
	int recv_stall_pct = 57;

	logic [KEY_W-1:0] key_pattern = '0;
	logic [1:0]       knob_code = KNOB_00;
	logic             turn_dir = 1'b1;
	int               pattern_left = 0;

	// {ms_tick, knob code, raw_keys}; knob code is {~pin_a, ~pin_b}
	logic [8:0] directed_scans [22] = '{
		9'h03F, 9'h17F, 9'h1C0, 9'h180, 9'h120, 9'h160, 9'h160, 9'h1E0,
		9'h060, 9'h020, 9'h100, 9'h100, 9'h0C0, 9'h080, 9'h000, 9'h1AA,
		9'h1D5, 9'h155, 9'h115, 9'h055, 9'h1BF, 9'h1C0
	};

	key_debounce_and_knob_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	kdk_scan_checker scan_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_scan(input logic [KEY_W-1:0] keys, input logic [1:0] code,
			input logic tick);
		if (scans_sent >= 580) begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
		end else if (scans_sent >= 290) begin
			send_gap_pct = 57;
			recv_stall_pct = 9;
		end
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = IN_TDATA_W'({tick, ~code[0], ~code[1], keys});
		do @(posedge clk); while (!s_tready);
		scans_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	// upper bits of the narrow registers carry junk that must be masked off
	task automatic set_phase(input int p);
		logic [7:0] junk_a;
		logic [7:0] junk_b;
		junk_a = 8'($urandom);
		junk_b = 8'($urandom);
		drain();
		write_reg(REG_DEBOUNCE_SCANS, {junk_a, 8'(PHASE_DEB[p])});
		write_reg(REG_LONG_PRESS, 16'(PHASE_LONG[p]));
		write_reg(REG_REPEAT, 16'(PHASE_REP[p]));
		write_reg(REG_KNOB_HOLDOFF, {junk_b, 8'(PHASE_HOLD[p])});
	endtask

	// held key patterns with some bounce, knob mostly walking in gray order
	task automatic run_scans(input int count, input int deb);
		logic [KEY_W-1:0] keys;
		int roll;
		for (int i = 0; i < count; i++) begin
			if (pattern_left == 0) begin
				case ($urandom_range(9))
					0, 1, 2, 3: key_pattern = KEY_SIX;
					4, 5:       key_pattern = '0;
					default:    key_pattern = KEY_W'($urandom);
				endcase
				pattern_left = (deb >= 16) ? $urandom_range(deb + 20, deb + 1)
					: $urandom_range(2 * deb + 12, 1);
			end
			pattern_left--;
			keys = (deb < 16 && $urandom_range(9) == 0) ? KEY_W'($urandom) : key_pattern;
			roll = $urandom_range(19);
			if (roll < 15) begin
				if (roll == 0) turn_dir = ~turn_dir;
				if (turn_dir) begin
					case (knob_code)
						KNOB_00: knob_code = KNOB_01;
						KNOB_01: knob_code = KNOB_11;
						KNOB_11: knob_code = KNOB_10;
						default: knob_code = KNOB_00;
					endcase
				end else begin
					case (knob_code)
						KNOB_00: knob_code = KNOB_10;
						KNOB_10: knob_code = KNOB_11;
						KNOB_11: knob_code = KNOB_01;
						default: knob_code = KNOB_00;
					endcase
				end
			end else if (roll >= 18) begin
				knob_code = 2'($urandom);
			end
			send_scan(keys, knob_code, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero debounce, short long press, zero repeat, short hold-off
		write_reg(REG_DEBOUNCE_SCANS, 16'hA500);
		write_reg(REG_LONG_PRESS, 16'd2);
		write_reg(REG_REPEAT, 16'd0);
		write_reg(REG_KNOB_HOLDOFF, 16'h5A02);
		foreach (directed_scans[i]) begin
			send_scan(directed_scans[i][5:0], directed_scans[i][7:6], directed_scans[i][8]);
		end
		knob_code = directed_scans[21][7:6];

		for (int p = 0; p < PHASES; p++) begin
			set_phase(p);
			run_scans(PHASE_SCANS[p], PHASE_DEB[p]);
		end

		drain();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
